// ===== rtl/core/bfr_pkg.sv =====
// Shared types and request codes for the bitstream field reader.
`timescale 1ns / 1ps

package bfr_pkg;

   // Request function codes
   localparam logic [2:0] FUNC_LOAD  = 3'd0;
   localparam logic [2:0] FUNC_FIXED = 3'd1;
   localparam logic [2:0] FUNC_VBR   = 3'd2;
   localparam logic [2:0] FUNC_ALIGN = 3'd3;
   localparam logic [2:0] FUNC_WORD  = 3'd4;
   localparam logic [2:0] FUNC_SEEK  = 3'd5;

   // Word index width of the read position and the stream length register
   localparam int POS_W = 13;

   // Sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LO   = 3'b010,
      ST_HI   = 3'b100
   } state_type;

endpackage

// ===== rtl/core/bfr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module bfr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bitstream_field_reader_unit.sv =====
// Top level of the bitstream field reader: position state, sequencer and word memory.
`timescale 1ns / 1ps

// Usage
//   Request channel: a word (req_func, req_address, req_data, req_width) is taken
//   at a rising edge with start high and busy low. Functions: load a memory word,
//   fixed-width read, VBR read, align, whole-word read, seek.
//   Result channel: rsp_value and rsp_failed are shown for exactly one cycle with
//   rsp_strobe high; the receiver cannot stall, so nothing ever waits on it.
//   Configuration: csr_write_en with csr_write_data sets the stream length in
//   words; write it only while the block is idle.
//   Sequencing: load, seek, align, zero-width reads and a VBR read of width one
//   finish in the accept cycle; a word read passes through ST_LO, a fixed read
//   through ST_LO and ST_HI, and a VBR read through ST_LO and ST_HI per chunk.
//   The result strobe is registered and comes in the cycle after the last state.
//   Busy stays high until then, so no new request is taken before the result.
//   Each chunk fetches the current and the following word through the single
//   read port of the word memory, one after the other; that port sets the rate.
//   Reset clears the position, the failure flag and the stream length; memory
//   contents are undefined until loaded.

module bitstream_field_reader_unit #(
   parameter int MEM_WORDS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [11:0] req_address,
   input  logic [31:0] req_data,
   input  logic [4:0]  req_width,
   output logic        rsp_strobe,
   output logic [63:0] rsp_value,
   output logic        rsp_failed,
   input  logic        csr_write_en,
   input  logic [12:0] csr_write_data
);

   localparam int PW = bfr_pkg::POS_W;
   localparam int AW = $clog2(MEM_WORDS);
   localparam int XW = (AW > PW) ? AW : PW;

   // control state
   bfr_pkg::state_type state_ff, state_in;
   logic [PW-1:0]  stream_words_ff;
   logic [PW-1:0]  word_pos_ff, word_pos_in;
   logic [4:0]     bit_off_ff, bit_off_in;
   logic           fail_ff, fail_in;
   logic           rsp_strobe_ff, rsp_strobe_in;
   logic           rd_ok_ff;
   // request and working registers
   logic [2:0]     func_ff, func_in;
   logic [4:0]     width_ff, width_in;
   logic [31:0]    lo_ff, lo_in;
   logic [63:0]    value_ff, value_in;
   logic [6:0]     shift_ff, shift_in;
   logic [63:0]    rsp_value_ff, rsp_value_in;
   logic           rsp_failed_ff, rsp_failed_in;

   // memory signals
   logic           accept;
   logic [PW-1:0]  rd_idx;
   logic [XW-1:0]  rd_idx_ext;
   logic [XW-1:0]  wr_idx_ext;
   logic           rd_ok;
   logic           wr_en;
   logic [31:0]    rd_data;
   logic [31:0]    mem_word;

   // chunk datapath
   logic [PW-1:0]  pos_inc;
   logic           at_end;
   logic           end_next;
   logic [5:0]     room;
   logic           straddle;
   logic [31:0]    lo_sh;
   logic [31:0]    hi_sh;
   logic [31:0]    field_mask;
   logic [31:0]    chunk_bits;
   logic           chunk_fail;
   logic [PW-1:0]  chunk_pos;
   logic [4:0]     chunk_off;
   logic           flag_bit;
   logic [63:0]    vbr_acc;
   logic [6:0]     vbr_shift;
   logic           chunk_fail_all;

   assign accept  = start && (state_ff == bfr_pkg::ST_IDLE);
   assign busy    = (state_ff != bfr_pkg::ST_IDLE);
   assign pos_inc = word_pos_ff + PW'(1);
   assign at_end  = (word_pos_ff >= stream_words_ff);

   // word memory
   assign wr_idx_ext = XW'(req_address);
   assign wr_en = accept && (req_func == bfr_pkg::FUNC_LOAD)
                  && (32'(req_address) < 32'(MEM_WORDS));
   assign rd_idx_ext = XW'(rd_idx);
   assign rd_ok      = (32'(rd_idx) < 32'(MEM_WORDS));

   bfr_ram #(
      .WIDTH (32),
      .DEPTH (MEM_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx_ext[AW-1:0]),
      .wr_data (req_data),
      .rd_addr (rd_idx_ext[AW-1:0]),
      .rd_data (rd_data)
   );

   // words past the memory read as zero
   assign mem_word = rd_ok_ff ? rd_data : 32'd0;

   // fixed-width chunk: low word in lo_ff, following word on the read port
   always_comb begin
      room       = 6'd32 - {1'b0, bit_off_ff};
      straddle   = (room <= {1'b0, width_ff});
      end_next   = (pos_inc >= stream_words_ff);
      lo_sh      = lo_ff >> bit_off_ff;
      hi_sh      = mem_word << room;
      field_mask = (32'd1 << width_ff) - 32'd1;
      chunk_bits = 32'd0;
      chunk_fail = 1'b0;
      chunk_pos  = word_pos_ff;
      chunk_off  = bit_off_ff;
      if (at_end) begin
         chunk_fail = 1'b1;
      end else if (straddle) begin
         chunk_pos = pos_inc;
         if (end_next) begin
            if (room < {1'b0, width_ff}) begin
               chunk_fail = 1'b1;
               chunk_bits = lo_sh;
            end else begin
               chunk_bits = lo_sh & field_mask;
               chunk_off  = 5'd0;
            end
         end else begin
            chunk_bits = (lo_sh | hi_sh) & field_mask;
            chunk_off  = 5'({1'b0, width_ff} - room);
         end
      end else begin
         chunk_bits = lo_sh & field_mask;
         chunk_off  = bit_off_ff + width_ff;
      end
      chunk_fail_all = fail_ff | chunk_fail;
   end

   // VBR accumulation of one chunk
   always_comb begin
      flag_bit  = chunk_bits[width_ff - 5'd1];
      vbr_acc   = value_ff
                  | (64'(chunk_bits & (field_mask >> 1)) << shift_ff[5:0]);
      vbr_shift = shift_ff + 7'(width_ff) - 7'd1;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      word_pos_in   = word_pos_ff;
      bit_off_in    = bit_off_ff;
      fail_in       = fail_ff;
      func_in       = func_ff;
      width_in      = width_ff;
      lo_in         = lo_ff;
      value_in      = value_ff;
      shift_in      = shift_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_failed_in = rsp_failed_ff;
      rd_idx        = word_pos_ff;
      case (state_ff)
         bfr_pkg::ST_IDLE: begin
            rd_idx = word_pos_ff;
            if (accept) begin
               func_in      = req_func;
               width_in     = req_width;
               value_in     = 64'd0;
               shift_in     = 7'd0;
               rsp_value_in = 64'd0;
               case (req_func)
                  bfr_pkg::FUNC_FIXED: begin
                     if (req_width != 5'd0) begin
                        state_in = bfr_pkg::ST_LO;
                     end
                  end
                  bfr_pkg::FUNC_VBR: begin
                     if (req_width == 5'd1) begin
                        fail_in = 1'b1;
                     end else if (req_width != 5'd0) begin
                        state_in = bfr_pkg::ST_LO;
                     end
                  end
                  bfr_pkg::FUNC_ALIGN: begin
                     if (bit_off_ff != 5'd0) begin
                        if (at_end) begin
                           fail_in = 1'b1;
                        end else begin
                           word_pos_in = pos_inc;
                           bit_off_in  = 5'd0;
                        end
                     end
                  end
                  bfr_pkg::FUNC_WORD: begin
                     state_in = bfr_pkg::ST_LO;
                  end
                  bfr_pkg::FUNC_SEEK: begin
                     word_pos_in = PW'(req_address);
                     bit_off_in  = req_width;
                  end
                  default: begin
                  end
               endcase
               // requests finished at once report in the next cycle
               if (state_in == bfr_pkg::ST_IDLE) begin
                  rsp_strobe_in = 1'b1;
                  rsp_failed_in = fail_in;
               end
            end
         end
         bfr_pkg::ST_LO: begin
            rd_idx = pos_inc;
            lo_in  = mem_word;
            if (func_ff == bfr_pkg::FUNC_WORD) begin
               if (at_end) begin
                  fail_in = 1'b1;
               end else begin
                  rsp_value_in = 64'(mem_word);
                  word_pos_in  = pos_inc;
               end
               rsp_strobe_in = 1'b1;
               rsp_failed_in = fail_in;
               state_in      = bfr_pkg::ST_IDLE;
            end else begin
               state_in = bfr_pkg::ST_HI;
            end
         end
         bfr_pkg::ST_HI: begin
            word_pos_in = chunk_pos;
            bit_off_in  = chunk_off;
            fail_in     = chunk_fail_all;
            rd_idx      = chunk_pos;
            if (func_ff == bfr_pkg::FUNC_VBR) begin
               value_in = vbr_acc;
               shift_in = vbr_shift;
               if (flag_bit && !chunk_fail_all && (vbr_shift < 7'd64)) begin
                  state_in = bfr_pkg::ST_LO;
               end else begin
                  // unterminated chain sets the sticky flag
                  fail_in       = chunk_fail_all | flag_bit;
                  rsp_value_in  = vbr_acc;
                  rsp_failed_in = chunk_fail_all | flag_bit;
                  rsp_strobe_in = 1'b1;
                  state_in      = bfr_pkg::ST_IDLE;
               end
            end else begin
               rsp_value_in  = 64'(chunk_bits);
               rsp_failed_in = chunk_fail_all;
               rsp_strobe_in = 1'b1;
               state_in      = bfr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bfr_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= bfr_pkg::ST_IDLE;
         stream_words_ff <= '0;
         word_pos_ff     <= '0;
         bit_off_ff      <= '0;
         fail_ff         <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         word_pos_ff   <= word_pos_in;
         bit_off_ff    <= bit_off_in;
         fail_ff       <= fail_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_en) begin
            stream_words_ff <= csr_write_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_ok_ff      <= rd_ok;
      func_ff       <= func_in;
      width_ff      <= width_in;
      lo_ff         <= lo_in;
      value_ff      <= value_in;
      shift_ff      <= shift_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_failed_ff <= rsp_failed_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_failed = rsp_failed_ff;

endmodule

// ===== sim/tb_bitstream_field_reader_unit.sv =====
// Self-checking testbench for the bitstream field reader: directed script, then random words.
`timescale 1ns / 1ps

module tb_bitstream_field_reader_unit;

   localparam int MEM_DEPTH    = 4096;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 200;
   localparam int RANDOM_WORDS = 1250;
   localparam int REPORT_MAX   = 10;

   // Function codes the block decodes to nothing
   localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [2:0]  func;
      logic [11:0] address;
      logic [31:0] data;
      logic [4:0]  width;
   } request_type;

   typedef struct packed {
      logic [63:0] value;
      logic        failed;
   } reply_type;

   // Read position and sticky failure flag
   typedef struct packed {
      logic [12:0] word_pos;
      logic [4:0]  bit_off;
      logic        failed;
   } cursor_type;

   // One line of the directed script: either a length write or a request word
   typedef struct packed {
      bit          is_len;
      logic [12:0] length;
      request_type req;
      bit          typed;
      reply_type   want;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_func = '0;
   logic [11:0] req_address = '0;
   logic [31:0] req_data = '0;
   logic [4:0]  req_width = '0;
   logic        rsp_strobe;
   logic [63:0] rsp_value;
   logic        rsp_failed;
   logic        csr_write_en = 1'b0;
   logic [12:0] csr_write_data = '0;

   bitstream_field_reader_unit #(
      .MEM_WORDS(MEM_DEPTH)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_address   (req_address),
      .req_data      (req_data),
      .req_width     (req_width),
      .rsp_strobe    (rsp_strobe),
      .rsp_value     (rsp_value),
      .rsp_failed    (rsp_failed),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Mirror of the block's state
   logic [31:0] stream_mem [MEM_DEPTH];
   bit          word_loaded [MEM_DEPTH];
   logic [12:0] stream_len = '0;
   cursor_type  cursor = '0;

   // Set when a prediction touches a memory word never loaded
   bit          touched_blank;
   logic [11:0] blank_index;

   reply_type   pending_replies [$];
   int          fault_count = 0;
   int          words_sent = 0;
   int          idle_cycles = 0;
   int          sender_idle_pct = 0;
   bit          req_live = 1'b0;

   function automatic logic [31:0] fetch_word(input logic [12:0] idx);
      if (int'(idx) >= MEM_DEPTH)
         return '0;
      if (!word_loaded[idx]) begin
         touched_blank = 1'b1;
         blank_index   = idx[11:0];
      end
      return stream_mem[idx];
   endfunction

   // Fixed-width field, LSB first, possibly straddling two words
   function automatic logic [31:0] take_bits(inout cursor_type c, input logic [4:0] w);
      logic [31:0] bits;
      logic [5:0]  room;
      if (w == 0)
         return '0;
      if (c.word_pos >= stream_len) begin
         c.failed = 1'b1;
         return '0;
      end
      bits = fetch_word(c.word_pos) >> c.bit_off;
      room = 6'd32 - {1'b0, c.bit_off};
      if (room <= {1'b0, w}) begin
         c.word_pos = c.word_pos + 13'd1;
         if (c.word_pos >= stream_len) begin
            // ran out of stream: keep the partial bits, offset stays put
            if (room < {1'b0, w}) begin
               c.failed = 1'b1;
               return bits;
            end
         end else begin
            bits = bits | (fetch_word(c.word_pos) << room);
         end
         c.bit_off = w - room[4:0];
      end else begin
         c.bit_off = c.bit_off + w;
      end
      return bits & ((32'd1 << w) - 32'd1);
   endfunction

   // Chain of chunks, w-1 payload bits each plus a continuation bit on top
   function automatic logic [63:0] take_vbr(inout cursor_type c, input logic [4:0] w);
      logic [31:0] bits;
      logic [31:0] flag;
      logic [31:0] mask;
      logic [63:0] acc;
      int          shift;
      acc   = '0;
      shift = 0;
      if (w == 0)
         return '0;
      if (w == 1 || c.word_pos >= stream_len) begin
         c.failed = 1'b1;
         return '0;
      end
      flag = 32'd1 << (w - 5'd1);
      mask = flag - 32'd1;
      do begin
         bits  = take_bits(c, w);
         acc   = acc | ({32'd0, bits & mask} << shift);
         shift = shift + int'(w) - 1;
      end while ((bits & flag) != 0 && !c.failed && shift < 64);
      if ((bits & flag) != 0)
         c.failed = 1'b1;
      return acc;
   endfunction

   // Result of one request word and its effect on the position
   function automatic reply_type bitstream_reply(input request_type r, inout cursor_type c);
      reply_type rep;
      rep.value = '0;
      case (r.func)
         bfr_pkg::FUNC_LOAD: begin
            stream_mem[r.address]  = r.data;
            word_loaded[r.address] = 1'b1;
         end
         bfr_pkg::FUNC_FIXED: rep.value = {32'd0, take_bits(c, r.width)};
         bfr_pkg::FUNC_VBR:   rep.value = take_vbr(c, r.width);
         bfr_pkg::FUNC_ALIGN: begin
            if (c.bit_off != 0) begin
               if (c.word_pos >= stream_len) begin
                  c.failed = 1'b1;
               end else begin
                  c.word_pos = c.word_pos + 13'd1;
                  c.bit_off  = '0;
               end
            end
         end
         bfr_pkg::FUNC_WORD: begin
            // offset is ignored and kept
            if (c.word_pos >= stream_len) begin
               c.failed = 1'b1;
            end else begin
               rep.value  = {32'd0, fetch_word(c.word_pos)};
               c.word_pos = c.word_pos + 13'd1;
            end
         end
         bfr_pkg::FUNC_SEEK: begin
            c.word_pos = {1'b0, r.address};
            c.bit_off  = r.width;
         end
         default: ;
      endcase
      rep.failed = c.failed;
      return rep;
   endfunction

   function automatic script_row_type op_row(input logic [2:0] f, input logic [11:0] a,
                                             input logic [31:0] d, input logic [4:0] w,
                                             input bit typed = 1'b0,
                                             input logic [63:0] v = '0,
                                             input logic fl = 1'b0);
      script_row_type row;
      row.is_len = 1'b0;
      row.length = '0;
      row.req    = '{func: f, address: a, data: d, width: w};
      row.typed  = typed;
      row.want   = '{value: v, failed: fl};
      return row;
   endfunction

   function automatic script_row_type length_row(input logic [12:0] len);
      script_row_type row;
      row        = '0;
      row.is_len = 1'b1;
      row.length = len;
      return row;
   endfunction

   function automatic logic [31:0] data_word();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10)
         return 32'hFFFF_FFFF;
      if (roll < 15)
         return '0;
      return $urandom;
   endfunction

   function automatic logic [12:0] pick_length();
      int roll;
      roll = $urandom_range(19);
      case (roll)
         0:       return 13'd0;
         1:       return 13'd1;
         2:       return 13'd4096;
         3:       return 13'($urandom_range(256, 4095));
         4, 5:    return 13'($urandom_range(25, 200));
         default: return 13'($urandom_range(2, 24));
      endcase
   endfunction

   // Random request, weighted towards reads near the live part of the stream
   function automatic request_type pick_request();
      request_type r;
      int          roll;
      int          span;
      span      = (stream_len > 13'd4094) ? 4095 : int'(stream_len) + 1;
      r.address = 12'($urandom);
      r.data    = data_word();
      r.width   = 5'($urandom);
      roll      = $urandom_range(99);
      if (roll < 10) begin
         r.func = bfr_pkg::FUNC_LOAD;
         if ($urandom_range(3) != 0)
            r.address = 12'($urandom_range(0, span));
      end else if (roll < 40) begin
         r.func = bfr_pkg::FUNC_FIXED;
      end else if (roll < 62) begin
         r.func = bfr_pkg::FUNC_VBR;
         if ($urandom_range(2) == 0)
            r.width = 5'($urandom_range(2, 6));
      end else if (roll < 70) begin
         r.func = bfr_pkg::FUNC_ALIGN;
      end else if (roll < 78) begin
         r.func = bfr_pkg::FUNC_WORD;
      end else if (roll < 95) begin
         r.func = bfr_pkg::FUNC_SEEK;
         if ($urandom_range(4) != 0)
            r.address = 12'($urandom_range(0, span));
      end else begin
         r.func = ($urandom_range(1) != 0) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
      end
      return r;
   endfunction

   // Present one word and wait for it to be taken; log what should come back
   task automatic issue(input request_type r, input bit typed, input reply_type want);
      reply_type got;
      req_func    <= r.func;
      req_address <= r.address;
      req_data    <= r.data;
      req_width   <= r.width;
      start       <= 1'b1;
      req_live     = 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      got = bitstream_reply(r, cursor);
      pending_replies.push_back(typed ? want : got);
      words_sent++;
   endtask

   task automatic pause_sender();
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         start   <= 1'b0;
         req_live = 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct);
      end
   endtask

   // Random read: first load any word it would touch that holds nothing yet
   task automatic issue_checked(input request_type r);
      cursor_type  probe;
      request_type fill;
      do begin
         touched_blank = 1'b0;
         if (r.func == bfr_pkg::FUNC_FIXED || r.func == bfr_pkg::FUNC_VBR
             || r.func == bfr_pkg::FUNC_WORD) begin
            probe = cursor;
            void'(bitstream_reply(r, probe));
         end
         if (touched_blank) begin
            fill = '{func: bfr_pkg::FUNC_LOAD, address: blank_index, data: data_word(),
                     width: 5'($urandom)};
            issue(fill, 1'b0, '0);
            pause_sender();
         end
      end while (touched_blank);
      issue(r, 1'b0, '0);
   endtask

   task automatic drain_replies();
      if (req_live) begin
         start   <= 1'b0;
         req_live = 1'b0;
      end
      while (pending_replies.size() != 0 || busy)
         @(posedge clock);
   endtask

   task automatic write_length(input logic [12:0] len);
      drain_replies();
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= len;
      @(posedge clock);
      csr_write_en <= 1'b0;
      stream_len    = len;
   endtask

   // Result checker
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_strobe) begin
         if (pending_replies.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
               $display("unexpected result word: value %h failed %b", rsp_value, rsp_failed);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_value !== want.value || rsp_failed !== want.failed) begin
               fault_count++;
               if (fault_count <= REPORT_MAX)
                  $display("mismatch at %0t: expected value %h failed %b, got value %h failed %b",
                           $realtime, want.value, want.failed, rsp_value, rsp_failed);
            end
         end
      end
   end

   // Watchdog: cycles in which no word moves on either channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      script_row_type script [$];
      request_type    r;
      int             idle_plan [3];
      int             goal;
      int             ep_len;

      // Directed script; typed results are the obvious ones
      script.push_back(op_row(FUNC_SPARE_LO, 12'h000, 32'h0000_0000, 5'd0, 1, 64'd0, 1'b0));
      script.push_back(op_row(FUNC_SPARE_HI, 12'hFFF, 32'hFFFF_FFFF, 5'd31, 1, 64'd0, 1'b0));
      script.push_back(op_row(bfr_pkg::FUNC_LOAD, 12'd0, 32'hFFFF_FFFF, 5'd0, 1, 64'd0, 1'b0));
      script.push_back(op_row(bfr_pkg::FUNC_LOAD, 12'd1, 32'h0000_0000, 5'd31, 1, 64'd0, 1'b0));
      script.push_back(op_row(bfr_pkg::FUNC_LOAD, 12'd2, 32'hA5C3_0F81, 5'd7, 1, 64'd0, 1'b0));
      script.push_back(op_row(bfr_pkg::FUNC_LOAD, 12'd3, 32'hFFFF_FFFF, 5'd0, 1, 64'd0, 1'b0));
      script.push_back(op_row(bfr_pkg::FUNC_LOAD, 12'hFFF, 32'h8000_0001, 5'd0, 1, 64'd0,
                              1'b0));
      script.push_back(length_row(13'd3));
      // zero width, widest (31-bit) read, straddling read
      script.push_back(op_row(bfr_pkg::FUNC_FIXED, 12'd0, 32'd0, 5'd0, 1, 64'd0, 1'b0));
      script.push_back(op_row(bfr_pkg::FUNC_FIXED, 12'd0, 32'd0, 5'd31, 1, 64'h7FFF_FFFF,
                              1'b0));
      script.push_back(op_row(bfr_pkg::FUNC_FIXED, 12'd0, 32'd0, 5'd3));
      script.push_back(op_row(bfr_pkg::FUNC_VBR, 12'd0, 32'd0, 5'd0, 1, 64'd0, 1'b0));
      script.push_back(op_row(bfr_pkg::FUNC_SEEK, 12'd2, 32'd0, 5'd0, 1, 64'd0, 1'b0));
      script.push_back(op_row(bfr_pkg::FUNC_VBR, 12'd0, 32'd0, 5'd4));
      script.push_back(op_row(bfr_pkg::FUNC_ALIGN, 12'd0, 32'd0, 5'd0));
      // word read ignores the offset, align then moves on
      script.push_back(op_row(bfr_pkg::FUNC_SEEK, 12'd0, 32'd0, 5'd31, 1, 64'd0, 1'b0));
      script.push_back(op_row(bfr_pkg::FUNC_WORD, 12'd0, 32'd0, 5'd0, 1, 64'hFFFF_FFFF, 1'b0));
      script.push_back(op_row(bfr_pkg::FUNC_ALIGN, 12'd0, 32'd0, 5'd0, 1, 64'd0, 1'b0));
      // field ending exactly on the stream end, then a word read past it
      script.push_back(op_row(bfr_pkg::FUNC_FIXED, 12'd0, 32'd0, 5'd31));
      script.push_back(op_row(bfr_pkg::FUNC_FIXED, 12'd0, 32'd0, 5'd1));
      script.push_back(op_row(bfr_pkg::FUNC_WORD, 12'd0, 32'd0, 5'd0, 1, 64'd0, 1'b1));
      script.push_back(length_row(13'd4));
      script.push_back(op_row(bfr_pkg::FUNC_SEEK, 12'd0, 32'd0, 5'd0, 1, 64'd0, 1'b1));
      script.push_back(op_row(bfr_pkg::FUNC_VBR, 12'd0, 32'd0, 5'd2));
      // chunk chain running off the end, and the illegal chunk width of one
      script.push_back(op_row(bfr_pkg::FUNC_SEEK, 12'd3, 32'd0, 5'd0, 1, 64'd0, 1'b1));
      script.push_back(op_row(bfr_pkg::FUNC_VBR, 12'd0, 32'd0, 5'd31));
      script.push_back(op_row(bfr_pkg::FUNC_VBR, 12'd0, 32'd0, 5'd1, 1, 64'd0, 1'b1));
      script.push_back(length_row(13'd4096));
      script.push_back(op_row(bfr_pkg::FUNC_SEEK, 12'hFFF, 32'd0, 5'd16, 1, 64'd0, 1'b1));
      script.push_back(op_row(bfr_pkg::FUNC_FIXED, 12'd0, 32'd0, 5'd31));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle_pct = 6;
      foreach (script[i]) begin
         if (script[i].is_len) begin
            write_length(script[i].length);
         end else begin
            issue(script[i].req, script[i].typed, script[i].want);
            pause_sender();
         end
      end

      // Random part: light sender gaps, heavy gaps, then back to back
      idle_plan = '{6, 79, 0};
      foreach (idle_plan[p]) begin
         sender_idle_pct = idle_plan[p];
         goal = words_sent + RANDOM_WORDS / 3;
         while (words_sent < goal) begin
            // each stretch: new length with the block idle, rewind, then random traffic
            write_length(pick_length());
            r = '{func: bfr_pkg::FUNC_SEEK, address: 12'd0, data: data_word(),
                  width: 5'($urandom_range(0, 3))};
            issue(r, 1'b0, '0);
            ep_len = $urandom_range(15, 60);
            repeat (ep_len) begin
               issue_checked(pick_request());
               pause_sender();
            end
         end
      end

      drain_replies();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && pending_replies.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
